// File: hdl/lrbd_pkg.sv
// Shared constants and types of the luma row boundary detector.
package lrbd_pkg;

  localparam int LUMA_W    = 8;
  localparam int CFG_W     = 13;
  localparam int THR_W     = 8;
  localparam int ACC_W     = 20;
  localparam int ROW_OUT_W = 12;
  localparam int PAIR_W    = 11;
  localparam int CFG_IDX_W = 2;
  localparam int OUT_DATA_W = 48;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int DEF_QUEUE_DEPTH = 4;

  localparam logic [CFG_W-1:0] RST_FRAME_WIDTH    = 13'd1920;
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT   = 13'd1080;
  localparam logic [THR_W-1:0] RST_MEAN_THRESHOLD = 8'd32;

  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH    = 2'd0,
    REG_FRAME_HEIGHT   = 2'd1,
    REG_MEAN_THRESHOLD = 2'd2
  } cfg_reg_t;

  // Per-pixel classification handed from the front to the back
  typedef struct packed {
    logic clr;         // clear accumulator and skip flag before this pixel
    logic has_prev;    // row above exists, accumulate the difference
    logic row_end;     // last pixel of its row
    logic wrap_after;  // row counter wraps after this row
  } ctl_t;

endpackage

// File: hdl/lrbd_front.sv
// Front end: column/row counters and per-pixel classification.
module lrbd_front #(
  parameter int MAX_WIDTH  = lrbd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lrbd_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 accept,
  input  logic                                 frame_start,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]       eff_width,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]      eff_height,
  output lrbd_pkg::ctl_t                       ctl,
  output logic [$clog2(MAX_WIDTH)-1:0]         col,
  output logic [$clog2(MAX_HEIGHT)-1:0]        upper
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WCNT_W = $clog2(MAX_WIDTH+1);
  localparam int HCNT_W = $clog2(MAX_HEIGHT+1);

  logic [COL_W-1:0]  col_r, col_nxt, col_s, col_c;
  logic [ROW_W-1:0]  row_r, row_nxt, row_s, row_c;
  logic [HCNT_W-1:0] row_inc;
  logic              row_wrap;

  always_comb begin
    col_s    = frame_start ? '0 : col_r;
    row_s    = frame_start ? '0 : row_r;
    // width lowered mid-row: clamp to the last column
    col_c    = (WCNT_W'(col_s) >= eff_width) ? COL_W'(eff_width - 1'b1) : col_s;
    row_wrap = (HCNT_W'(row_s) >= eff_height);
    row_c    = row_wrap ? '0 : row_s;
    row_inc  = HCNT_W'(row_c) + 1'b1;

    ctl.clr        = frame_start | row_wrap;
    ctl.has_prev   = (row_c != '0);
    ctl.row_end    = ((WCNT_W'(col_c) + 1'b1) >= eff_width);
    ctl.wrap_after = (row_inc >= eff_height);

    col   = col_c;
    upper = row_c - 1'b1;

    if (ctl.row_end) begin
      col_nxt = '0;
      row_nxt = ctl.wrap_after ? '0 : ROW_W'(row_inc);
    end else begin
      col_nxt = col_c + 1'b1;
      row_nxt = row_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// File: hdl/lrbd_queue.sv
// Small flop-based queue between the front and back ends.
module lrbd_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = lrbd_pkg::DEF_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] din,
  input  logic              pop,
  output logic [DATA_W-1:0] dout,
  output logic              not_empty,
  output logic              not_full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH+1);

  logic [DATA_W-1:0] entry_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r;

  assign dout      = entry_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign not_full  = (count_r != CNT_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0) else $error("queue popped while empty");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> count_r != CNT_W'(DEPTH)) else $error("queue pushed while full");
`endif

endmodule

// File: hdl/lrbd_back.sv
// Back end: line store, row difference accumulator, boundary decision, result register.
module lrbd_back #(
  parameter int MAX_WIDTH  = lrbd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lrbd_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  q_valid,
  output logic                                  q_pop,
  input  lrbd_pkg::ctl_t                        q_ctl,
  input  logic [lrbd_pkg::LUMA_W-1:0]           q_pix,
  input  logic [$clog2(MAX_WIDTH)-1:0]          q_col,
  input  logic [$clog2(MAX_HEIGHT)-1:0]         q_upper,
  input  logic [lrbd_pkg::THR_W+$clog2(MAX_WIDTH+1):0] thr_prod,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [lrbd_pkg::ROW_OUT_W-1:0]        out_row,
  output logic [lrbd_pkg::PAIR_W-1:0]           out_pair,
  output logic [lrbd_pkg::ACC_W-1:0]            out_delta
);

  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int ACC_W = lrbd_pkg::ACC_W;

  logic [lrbd_pkg::LUMA_W-1:0] store [MAX_WIDTH];

  logic                        s1_v_r;
  lrbd_pkg::ctl_t              s1_ctl_r;
  logic [lrbd_pkg::LUMA_W-1:0] s1_pix_r, s1_old_r;
  logic [ROW_W-1:0]            s1_upper_r;

  logic [ACC_W-1:0] acc_r, acc_nxt, acc_base, acc_sum;
  logic [ACC_W:0]   acc_wide;
  logic             skip_r, skip_nxt, skip_base;
  logic [lrbd_pkg::LUMA_W-1:0] diff;
  logic             flagged, emit;
  logic             adv, load;

  logic                           out_v_r;
  logic [lrbd_pkg::ROW_OUT_W-1:0] out_row_r;
  logic [lrbd_pkg::PAIR_W-1:0]    out_pair_r;
  logic [ACC_W-1:0]               out_delta_r;

  assign adv   = !out_v_r || out_ready;
  assign load  = q_valid && (!s1_v_r || adv);
  assign q_pop = load;

  // read-before-write: the old sample of this column comes out registered
  always_ff @(posedge clk) begin
    if (load) begin
      s1_old_r     <= store[q_col];
      store[q_col] <= q_pix;
      s1_pix_r     <= q_pix;
      s1_ctl_r     <= q_ctl;
      s1_upper_r   <= q_upper;
    end
  end

  always_comb begin
    diff      = (s1_pix_r > s1_old_r) ? s1_pix_r - s1_old_r : s1_old_r - s1_pix_r;
    acc_base  = s1_ctl_r.clr ? '0 : acc_r;
    skip_base = s1_ctl_r.clr ? 1'b0 : skip_r;
    acc_wide  = {1'b0, acc_base} + (ACC_W+1)'(diff);
    if (!s1_ctl_r.has_prev) begin
      acc_sum = acc_base;
    end else if (acc_wide[ACC_W]) begin
      acc_sum = lrbd_pkg::ACC_MAX;
    end else begin
      acc_sum = acc_wide[ACC_W-1:0];
    end
    // floor(acc / width) > thr  <=>  acc >= (thr + 1) * width
    flagged  = (32'(acc_sum) >= 32'(thr_prod));
    emit     = 1'b0;
    skip_nxt = skip_base;
    acc_nxt  = acc_sum;
    if (s1_ctl_r.row_end) begin
      acc_nxt = '0;
      if (s1_ctl_r.has_prev) begin
        if (skip_base) begin
          skip_nxt = 1'b0;
        end else if (flagged) begin
          emit     = 1'b1;
          skip_nxt = !s1_upper_r[0];
        end
      end
      if (s1_ctl_r.wrap_after) begin
        skip_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      acc_r   <= '0;
      skip_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (!s1_v_r || adv) begin
        s1_v_r <= q_valid;
      end
      if (s1_v_r && adv) begin
        acc_r  <= acc_nxt;
        skip_r <= skip_nxt;
      end
      if (adv) begin
        out_v_r <= s1_v_r && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_v_r && emit) begin
      out_row_r   <= lrbd_pkg::ROW_OUT_W'(s1_upper_r);
      out_pair_r  <= lrbd_pkg::PAIR_W'(s1_upper_r >> 1);
      out_delta_r <= acc_sum;
    end
  end

  assign out_valid = out_v_r;
  assign out_row   = out_row_r;
  assign out_pair  = out_pair_r;
  assign out_delta = out_delta_r;

`ifndef NO_ASSERTIONS
  a_skip_after_even: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skip_r) |-> out_v_r && !out_row_r[0])
    else $error("skip set without an even boundary result");
  a_delta_row_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> out_pair_r == lrbd_pkg::PAIR_W'(out_row_r >> 1))
    else $error("paint pair does not match boundary row");
`endif

endmodule

// File: hdl/luma_row_boundary_detector_unit.sv
// Top level of the luma row boundary detector.
//
//  channel | direction | beat contents
//  --------+-----------+---------------------------------------------------------
//  in_     | slave     | tdata[7:0] luma_pixel, tuser frame_start
//  out_    | master    | tdata[11:0] boundary_row, [22:12] paint_pair, [42:23] row_delta
//  cfg_    | slave     | cfg_index register, cfg_data value (always ready)
//
//  One pixel per clock sustained while out_ is ready; the line store has one read and
//  one write per pixel. Results pass the queue, stage s1 and the result register.
//  Reset (rst_n low, synchronous) clears counters, accumulator and skip flag;
//  the line store is not cleared. Back-pressure on out_ fills the four-entry
//  queue, then drops in_tready.
module luma_row_boundary_detector_unit #(
  parameter int MAX_WIDTH  = lrbd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lrbd_pkg::DEF_MAX_HEIGHT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,   // [7:0] luma_pixel
  input  logic                               in_tuser,   // [0] frame_start
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [lrbd_pkg::OUT_DATA_W-1:0]    out_tdata,  // boundary_row, paint_pair, row_delta
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lrbd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lrbd_pkg::CFG_W-1:0]         cfg_data
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WCNT_W = $clog2(MAX_WIDTH+1);
  localparam int HCNT_W = $clog2(MAX_HEIGHT+1);
  localparam int PROD_W = lrbd_pkg::THR_W + WCNT_W + 1;
  localparam int CTL_W  = $bits(lrbd_pkg::ctl_t);
  localparam int Q_W    = ROW_W + COL_W + lrbd_pkg::LUMA_W + CTL_W;

  logic [lrbd_pkg::CFG_W-1:0] frame_width_r, frame_height_r;
  logic [lrbd_pkg::THR_W-1:0] mean_threshold_r;
  logic [WCNT_W-1:0]          eff_width;
  logic [HCNT_W-1:0]          eff_height;
  logic [PROD_W-1:0]          thr_prod_r;

  logic                          in_accept;
  lrbd_pkg::ctl_t                f_ctl, q_ctl;
  logic [COL_W-1:0]              f_col, q_col;
  logic [ROW_W-1:0]              f_upper, q_upper;
  logic [lrbd_pkg::LUMA_W-1:0]   q_pix;
  logic [Q_W-1:0]                q_din, q_dout;
  logic                          q_not_empty, q_not_full, q_pop;

  logic [lrbd_pkg::ROW_OUT_W-1:0] out_row;
  logic [lrbd_pkg::PAIR_W-1:0]    out_pair;
  logic [lrbd_pkg::ACC_W-1:0]     out_delta;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r    <= lrbd_pkg::RST_FRAME_WIDTH;
      frame_height_r   <= lrbd_pkg::RST_FRAME_HEIGHT;
      mean_threshold_r <= lrbd_pkg::RST_MEAN_THRESHOLD;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lrbd_pkg::REG_FRAME_WIDTH:    frame_width_r    <= cfg_data;
        lrbd_pkg::REG_FRAME_HEIGHT:   frame_height_r   <= cfg_data;
        lrbd_pkg::REG_MEAN_THRESHOLD: mean_threshold_r <= cfg_data[lrbd_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_width_r == '0) begin
      eff_width = WCNT_W'(1);
    end else if (32'(frame_width_r) > 32'(MAX_WIDTH)) begin
      eff_width = WCNT_W'(MAX_WIDTH);
    end else begin
      eff_width = WCNT_W'(frame_width_r);
    end
    if (frame_height_r == '0) begin
      eff_height = HCNT_W'(1);
    end else if (32'(frame_height_r) > 32'(MAX_HEIGHT)) begin
      eff_height = HCNT_W'(MAX_HEIGHT);
    end else begin
      eff_height = HCNT_W'(frame_height_r);
    end
  end

  // mean compare threshold, refreshed every cycle from the registers
  always_ff @(posedge clk) begin
    thr_prod_r <= (PROD_W'(mean_threshold_r) + 1'b1) * PROD_W'(eff_width);
  end

  assign in_tready = q_not_full;
  assign in_accept = in_tvalid && in_tready;

  lrbd_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .frame_start (in_tuser),
    .eff_width   (eff_width),
    .eff_height  (eff_height),
    .ctl         (f_ctl),
    .col         (f_col),
    .upper       (f_upper)
  );

  assign q_din = {f_upper, f_col, in_tdata, f_ctl};
  assign {q_upper, q_col, q_pix, q_ctl} = q_dout;

  lrbd_queue #(
    .DATA_W (Q_W),
    .DEPTH  (lrbd_pkg::DEF_QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .din       (q_din),
    .pop       (q_pop),
    .dout      (q_dout),
    .not_empty (q_not_empty),
    .not_full  (q_not_full)
  );

  lrbd_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_not_empty),
    .q_pop     (q_pop),
    .q_ctl     (q_ctl),
    .q_pix     (q_pix),
    .q_col     (q_col),
    .q_upper   (q_upper),
    .thr_prod  (thr_prod_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_row   (out_row),
    .out_pair  (out_pair),
    .out_delta (out_delta)
  );

  assign out_tdata = {
    {(lrbd_pkg::OUT_DATA_W - lrbd_pkg::ACC_W - lrbd_pkg::PAIR_W - lrbd_pkg::ROW_OUT_W){1'b0}},
    out_delta, out_pair, out_row
  };

endmodule
